[rtl/oaie_pkg.sv]
// Shared constants, command and status codes, and controller/datapath link types.
package oaie_pkg;

  localparam int unsigned OAIE_DEPTH     = 64;
  localparam int unsigned OAIE_WORD_BITS = 32;

  localparam int unsigned CMD_BITS     = 3;
  localparam int unsigned POS_BITS     = 6;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned STATUS_BITS  = 2;
  localparam int unsigned COUNT_BITS   = 7;
  localparam int unsigned S_TDATA_BITS = 40;
  localparam int unsigned M_TDATA_BITS = 40;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // capture the incoming word
    logic check;     // latch status, apply single-step commands, set shift index
    logic rd_pos;    // read the memory at the requested position
    logic rd_src;    // read the source entry of the current shift step
    logic wr_shift;  // write the fetched entry to its new place and step the index
    logic finish;    // close an insert or erase
    logic load_res;  // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic is_read;
    logic is_shift;
    logic shift_more;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/ordered_array_insert_erase_unit.sv]
// Top level of the bounded ordered array with push, pop, insert, erase, clear and read.
//
// The unit holds up to DEPTH signed words in order and answers every command word with
// exactly one result word carrying the read value, a status and the element count after
// the command. Commands are handled one at a time. Push, pop, clear, read, an unknown
// command and any command that fails its check go from acceptance through the check
// and the result load back to idle. Insert at position p on an array of n entries moves
// n - p entries and erase at p moves n - p - 1: the entries move one at a time through the
// single memory port pair, each move being a read step followed by a write
// step. A new command word is taken as soon as the controller is idle, even while
// the previous result word still waits in the output register; the controller only
// stalls when a second result is ready before the first has been taken. A read of a
// stored word is returned sign-extended from WORD_BITS; a failed command changes nothing.
// There is no clearing pass: the memory contents are undefined after reset, which is
// harmless because only positions below the element count can be read.
module ordered_array_insert_erase_unit import oaie_pkg::*; #(
  parameter int unsigned DEPTH     = OAIE_DEPTH,
  parameter int unsigned WORD_BITS = OAIE_WORD_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [S_TDATA_BITS-1:0] s_axis_tdata,  // position[5:0], item_value[37:6], zeros
  input  logic [CMD_BITS-1:0]     s_axis_tuser,  // command[2:0]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [M_TDATA_BITS-1:0] m_axis_tdata,  // read_value[31:0], count[38:32], zero
  output logic [STATUS_BITS-1:0]  m_axis_tuser   // status[1:0]
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic signed [VALUE_BITS-1:0] read_value;
  logic [COUNT_BITS-1:0]        count;

  oaie_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_o     (dp_cmd),
    .stat_i    (dp_stat)
  );

  oaie_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (dp_cmd),
    .stat_o       (dp_stat),
    .command_i    (s_axis_tuser),
    .position_i   (s_axis_tdata[POS_BITS-1:0]),
    .item_value_i (s_axis_tdata[POS_BITS+VALUE_BITS-1:POS_BITS]),
    .res_ready_i  (m_axis_tready),
    .res_valid_o  (m_axis_tvalid),
    .read_value_o (read_value),
    .status_o     (m_axis_tuser),
    .count_o      (count)
  );

  // Pack the result word, padding the top bit with zero.
  assign m_axis_tdata = M_TDATA_BITS'({count, read_value});

endmodule

[rtl/oaie_dpath.sv]
// Datapath: entry memory, element count, shift index and result register.
module oaie_dpath import oaie_pkg::*; #(
  parameter int unsigned DEPTH     = OAIE_DEPTH,
  parameter int unsigned WORD_BITS = OAIE_WORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      ctl_i,
  output dp_stat_t                     stat_o,
  input  logic [CMD_BITS-1:0]          command_i,
  input  logic [POS_BITS-1:0]          position_i,
  input  logic signed [VALUE_BITS-1:0] item_value_i,
  input  logic                         res_ready_i,
  output logic                         res_valid_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic [STATUS_BITS-1:0]       status_o,
  output logic [COUNT_BITS-1:0]        count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_BITS) ? CW : POS_BITS;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_q;

  cmd_e                  cmd_q;
  logic [POS_BITS-1:0]   pos_q;
  logic [WORD_BITS-1:0]  val_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_inc, idx_dec, idx_src;
  status_e               st_q, st_d;
  logic                  res_valid_q, res_valid_d;
  logic [VALUE_BITS-1:0] res_value_q;
  status_e               res_status_q;
  logic [COUNT_BITS-1:0] res_count_q;

  logic [XW-1:0]        pos_x, cnt_x, idx_x;
  logic [AW-1:0]        pos_a;
  logic                 full, empty;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  assign pos_x   = XW'(pos_q);
  assign cnt_x   = XW'(cnt_q);
  assign idx_x   = XW'(idx_q);
  assign pos_a   = AW'(pos_q);
  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign idx_inc = idx_q + CW'(1);
  assign idx_dec = idx_q - CW'(1);
  assign idx_src = (cmd_q == CMD_INSERT) ? idx_dec : idx_inc;

  always_comb begin
    st_d = ST_OK;
    unique case (cmd_q) inside
      CMD_PUSH: begin
        if (full) st_d = ST_FULL;
      end
      CMD_POP: begin
        if (empty) st_d = ST_EMPTY;
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) st_d = ST_RANGE;
        else if (full)     st_d = ST_FULL;
      end
      CMD_ERASE, CMD_READ: begin
        if (pos_x >= cnt_x) st_d = ST_RANGE;
      end
      default: st_d = ST_OK;
    endcase
  end

  always_comb begin
    stat_o.err      = (st_d != ST_OK);
    stat_o.is_read  = (cmd_q == CMD_READ);
    stat_o.is_shift = (cmd_q == CMD_INSERT) || (cmd_q == CMD_ERASE);
    stat_o.shift_more = (cmd_q == CMD_INSERT) ? (idx_x > pos_x) : (idx_inc < cnt_q);
    stat_o.out_free = !res_valid_q || res_ready_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.check && (st_d == ST_OK)) begin
      case (cmd_q)
        CMD_PUSH:  cnt_d = cnt_q + CW'(1);
        CMD_POP:   cnt_d = cnt_q - CW'(1);
        CMD_CLEAR: cnt_d = '0;
        default:   cnt_d = cnt_q;
      endcase
    end
    if (ctl_i.finish) begin
      cnt_d = (cmd_q == CMD_INSERT) ? cnt_q + CW'(1) : cnt_q - CW'(1);
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    if (ctl_i.load_res)             res_valid_d = 1'b1;
  end

  // Memory port selection: push writes at the end, a shift step moves the
  // fetched entry, and a finished insert drops the new word into its slot.
  always_comb begin
    mem_we = (ctl_i.check && (st_d == ST_OK) && (cmd_q == CMD_PUSH)) || ctl_i.wr_shift ||
             (ctl_i.finish && (cmd_q == CMD_INSERT));
    mem_wa = pos_a;
    if (ctl_i.check)    mem_wa = cnt_q[AW-1:0];
    if (ctl_i.wr_shift) mem_wa = idx_q[AW-1:0];
    mem_wd = ctl_i.wr_shift ? rd_q : val_q;
    mem_re = ctl_i.rd_pos || ctl_i.rd_src;
    mem_ra = ctl_i.rd_src ? idx_src[AW-1:0] : pos_a;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cmd_q <= cmd_e'(command_i);
      pos_q <= position_i;
      val_q <= WORD_BITS'(item_value_i);
    end
    if (ctl_i.check) begin
      st_q  <= st_d;
      idx_q <= (cmd_q == CMD_ERASE) ? CW'(pos_q) : cnt_q;
    end
    if (ctl_i.wr_shift) begin
      idx_q <= (cmd_q == CMD_INSERT) ? idx_dec : idx_inc;
    end
    if (ctl_i.load_res) begin
      res_value_q  <= ((cmd_q == CMD_READ) && (st_q == ST_OK)) ?
                      VALUE_BITS'($signed(rd_q)) : '0;
      res_status_q <= st_q;
      res_count_q  <= COUNT_BITS'(cnt_q);
    end
  end

  assign res_valid_o  = res_valid_q;
  assign read_value_o = res_value_q;
  assign status_o     = res_status_q;
  assign count_o      = res_count_q;

endmodule

[rtl/oaie_ctrl.sv]
// Controller: sequences each command through check, shift steps and result load.
module oaie_ctrl import oaie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SH_RD = 3'd2;
  localparam logic [2:0] S_SH_WR = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.check = 1'b1;
        if (!stat_i.err && stat_i.is_shift) begin
          state_d = S_SH_RD;
        end else begin
          cmd_o.rd_pos = stat_i.is_read;
          state_d      = S_DONE;
        end
      end
      S_SH_RD: begin
        if (stat_i.shift_more) begin
          cmd_o.rd_src = 1'b1;
          state_d      = S_SH_WR;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_SH_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/oaie_checker.sv]
// Port-level checker for the ordered array unit and its bind to the top level.
module oaie_checker import oaie_pkg::*; #(
  parameter int unsigned DEPTH = OAIE_DEPTH
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [M_TDATA_BITS-1:0] m_axis_tdata,
  input logic [STATUS_BITS-1:0]  m_axis_tuser
);

  logic [COUNT_BITS-1:0] res_count;
  logic [VALUE_BITS-1:0] res_value;

  assign res_count = m_axis_tdata[VALUE_BITS+COUNT_BITS-1:VALUE_BITS];
  assign res_value = m_axis_tdata[VALUE_BITS-1:0];

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // A full report only comes with a full array, an empty report only with an empty one.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> res_count == COUNT_BITS'(DEPTH))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> res_count == '0)
    else $error("empty status with nonzero count");

  // A failed command never returns data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> res_value == '0)
    else $error("read value returned with a failing status");

  // A command word taken at one edge cannot give its result at the next one.
  a_no_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind ordered_array_insert_erase_unit oaie_checker #(.DEPTH(DEPTH)) u_oaie_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[sim/testbench.sv]
// Self-checking stream testbench for the bounded ordered array unit.
`timescale 1ns / 100ps

module testbench;
  import oaie_pkg::*;

  // Capacity as built, and the two command codes that the block must ignore.
  localparam int          ARRAY_DEPTH   = OAIE_DEPTH;
  localparam logic [2:0]  CMD_SPARE_6   = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7   = 3'd7;
  // A long receiver hold-off, long enough for the command side to back up.
  localparam int          HOLD_CYCLES   = 400;
  // The settle time at the end covers the slowest command (insert at the front
  // of a nearly full array) twice over.
  localparam int          SETTLE_CYCLES = 300;
  localparam int          CYCLE_LIMIT   = 1000000;

  // One command word as it travels on the slave side.
  typedef struct packed {
    logic [CMD_BITS-1:0]          command;
    logic [POS_BITS-1:0]          position;
    logic signed [VALUE_BITS-1:0] item_value;
  } command_word_t;

  // One result word as the array answers it.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] read_value;
    status_e                      status;
    logic [COUNT_BITS-1:0]        count;
  } array_result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [S_TDATA_BITS-1:0] s_axis_tdata  = '0;  // position[5:0], item_value[37:6], zeros
  logic [CMD_BITS-1:0]     s_axis_tuser  = '0;  // command[2:0]
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_axis_tdata;        // read_value[31:0], count[38:32], zero
  logic [STATUS_BITS-1:0]  m_axis_tuser;        // status[1:0]

  ordered_array_insert_erase_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Commands waiting to be offered, and results owed by the block in order.
  command_word_t pending_commands[$];
  array_result_t expected_results[$];

  // Our own copy of the array, advanced as each command word is accepted.
  logic signed [VALUE_BITS-1:0] stored_words [ARRAY_DEPTH];
  int                           stored_count = 0;

  // The word currently on the slave side.
  command_word_t offered;

  // Idle rates in percent for each side, changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The stimulus asks for a long hold-off by bumping hold_requests; the
  // receiver notices the difference and counts the hold down itself.
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  int mismatches  = 0;
  int cycle_count = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Works out the answer to one command and updates the array copy. The word
  // width equals the bus width here, so the sign extension on a read is the
  // identity. A command that fails leaves the copy untouched.
  function automatic array_result_t apply_command(command_word_t w);
    array_result_t r;
    int            i;
    r.read_value = '0;
    r.status     = ST_OK;
    case (w.command)
      CMD_PUSH: begin
        if (stored_count >= ARRAY_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stored_words[stored_count] = w.item_value;
          stored_count++;
        end
      end
      CMD_POP: begin
        if (stored_count == 0) r.status = ST_EMPTY;
        else stored_count--;
      end
      CMD_INSERT: begin
        // The position check takes priority over the full check.
        if (int'(w.position) > stored_count) begin
          r.status = ST_RANGE;
        end else if (stored_count >= ARRAY_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = stored_count; i > int'(w.position); i--) begin
            stored_words[i] = stored_words[i-1];
          end
          stored_words[w.position] = w.item_value;
          stored_count++;
        end
      end
      CMD_ERASE: begin
        if (int'(w.position) >= stored_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(w.position); i + 1 < stored_count; i++) begin
            stored_words[i] = stored_words[i+1];
          end
          stored_count--;
        end
      end
      // Clear only drops the count; the stored words keep their bits.
      CMD_CLEAR: stored_count = 0;
      CMD_READ: begin
        if (int'(w.position) >= stored_count) r.status = ST_RANGE;
        else r.read_value = stored_words[w.position];
      end
      // The two spare codes answer ok with the count unchanged.
      default: ;
    endcase
    r.count = COUNT_BITS'(stored_count);
    return r;
  endfunction

  // Command side. Each accepted word is run through the predictor at once, so
  // the expectation is queued well before the block can answer it. A word
  // stays on the bus until it is taken; only then may the sender idle.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    command_word_t next_word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(), apply_command(offered));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word     = pending_commands.pop_front();
          offered      <= next_word;
          s_axis_tdata  <= {2'b00, next_word.item_value, next_word.position};
          s_axis_tuser  <= next_word.command;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side. Every result word taken is matched against the oldest
  // expectation, field by field.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    array_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if ($signed(m_axis_tdata[31:0]) !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   $signed(m_axis_tdata[31:0]));
            mismatches++;
          end
          if (m_axis_tdata[38:32] !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, m_axis_tdata[38:32]);
            mismatches++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic queue_command(input logic [2:0] cmd, input logic [5:0] pos,
                               input logic [31:0] value);
    command_word_t w;
    w.command    = cmd;
    w.position   = pos;
    w.item_value = value;
    pending_commands.insert(pending_commands.size(), w);
  endtask

  // Random commands drawn around the array's present fill level. grow_pct
  // steers the mix towards push and insert (filling) or towards pop and erase
  // (draining); most positions land inside or just past the current range so
  // that the shifting paths get real work, with a tenth of them anywhere.
  // backlog bounds how far the queue may run ahead of the bus.
  task automatic queue_random_commands(input int n, input int grow_pct, input int backlog);
    int         k;
    int         top;
    int         pick;
    logic [2:0] cmd;
    logic [5:0] pos;
    for (k = 0; k < n; k++) begin
      while (pending_commands.size() >= backlog) @(posedge clk_i);
      pick = $urandom_range(0, 999);
      if (pick < 4) begin
        cmd = CMD_CLEAR;
      end else if (pick < 14) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_PUSH;
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_POP;
          1:       cmd = CMD_ERASE;
          default: cmd = CMD_READ;
        endcase
      end
      top = (stored_count > 63) ? 63 : stored_count;
      if ($urandom_range(0, 9) == 0) pos = 6'($urandom_range(0, 63));
      else pos = 6'($urandom_range(0, top));
      queue_command(cmd, pos, $urandom);
    end
  endtask

  // Holds the stimulus until every queued command has been answered.
  task automatic wait_until_settled();
    while (pending_commands.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int phase;
    int segment;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: everything that can go wrong on an empty array, the
    // extreme values, insert at the end, every read position in use, the two
    // spare codes, and clear followed by a fresh push.
    send_idle_pct = 10;
    recv_idle_pct = 67;
    queue_command(CMD_POP,    6'd0,  32'h0);
    queue_command(CMD_READ,   6'd0,  32'h0);
    queue_command(CMD_ERASE,  6'd0,  32'h0);
    queue_command(CMD_INSERT, 6'd1,  32'h1);
    queue_command(CMD_INSERT, 6'd0,  32'h8000_0000);
    queue_command(CMD_PUSH,   6'd0,  32'h7FFF_FFFF);
    queue_command(CMD_PUSH,   6'd63, 32'hFFFF_FFFF);
    queue_command(CMD_INSERT, 6'd1,  32'h0);
    queue_command(CMD_INSERT, 6'd4,  32'h5555_5555);
    queue_command(CMD_READ,   6'd0,  32'h0);
    queue_command(CMD_READ,   6'd1,  32'h0);
    queue_command(CMD_READ,   6'd2,  32'h0);
    queue_command(CMD_READ,   6'd3,  32'h0);
    queue_command(CMD_READ,   6'd4,  32'h0);
    queue_command(CMD_READ,   6'd5,  32'h0);
    queue_command(CMD_READ,   6'd63, 32'h0);
    queue_command(CMD_ERASE,  6'd5,  32'h0);
    queue_command(CMD_ERASE,  6'd0,  32'h0);
    queue_command(CMD_ERASE,  6'd3,  32'h0);
    queue_command(CMD_SPARE_6, 6'd63, 32'hAAAA_AAAA);
    queue_command(CMD_SPARE_7, 6'd42, 32'hFFFF_FFFF);
    queue_command(CMD_POP,    6'd0,  32'h0);
    queue_command(CMD_CLEAR,  6'd0,  32'h0);
    queue_command(CMD_READ,   6'd0,  32'h0);
    queue_command(CMD_PUSH,   6'd0,  32'h1234_5678);
    queue_command(CMD_READ,   6'd0,  32'h0);
    wait_until_settled();

    // Three idling phases. Each runs segments that alternately fill the array
    // to its capacity, hover, and drain it, so full, empty and long shifts all
    // come round many times.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 10; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (segment = 0; segment < 4; segment++) begin
        case (segment)
          0: queue_random_commands(150, 80, 2);
          1: queue_random_commands(120, 50, 2);
          2: queue_random_commands(140, 20, 2);
          default: queue_random_commands(110, 60, 2);
        endcase
        // Once, with a well filled array, the receiver holds off for a long
        // stretch while a backlog of commands keeps the command side busy.
        if (phase == 0 && segment == 1) begin
          queue_random_commands(40, 50, 40);
          hold_requests++;
        end
      end
      wait_until_settled();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/oaie_pkg.sv
rtl/oaie_dpath.sv
rtl/oaie_ctrl.sv
rtl/ordered_array_insert_erase_unit.sv
rtl/oaie_checker.sv
sim/testbench.sv
